/* rtl/core/groebner_pair_set_manager_assert.svh */
// Assertion macros for the pair-set manager core.
// Included by the datapath; depends on nothing.
`ifndef GROEBNER_PAIR_SET_MANAGER_ASSERT_SVH
`define GROEBNER_PAIR_SET_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define GPSM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpsm assertion failed");
`define GPSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpsm assertion failed");
`else
`define GPSM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define GPSM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/gpsm_pkg.sv */
// Shared types and codes for the pair-set manager core.
// No dependencies.
package gpsm_pkg;

   // operation codes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_DROP  = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] lead_exponents;
   } req_word_type;

   typedef struct packed {
      logic [4:0] pair_first;
      logic [4:0] pair_second;
      logic [1:0] status;
      logic [7:0] pairs_left;
      logic [5:0] basis_size;
   } rsp_word_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE,
      ST_CHK_I, ST_EV_I, ST_CHK_K, ST_EV_K,
      ST_FLT_CHK, ST_FLT_P, ST_FLT_1, ST_FLT_2,
      ST_APP_CHK, ST_APP_EV, ST_ADD_END,
      ST_POP_CHK, ST_POP_P, ST_POP_1, ST_POP_2, ST_POP_EV, ST_POP_SWAP,
      ST_FINISH
   } state_type;

   // monomial store read address source
   typedef enum logic [1:0] {
      SEL_I, SEL_K, SEL_FIRST, SEL_SECOND
   } store_sel_type;

   typedef struct packed {
      logic          load_item;
      logic          clear_all;
      logic          set_status;
      logic [1:0]    status_code;
      logic          add_init;
      logic          i_inc;
      logic          acc_set;
      logic          chain_start;
      logic          k_inc;
      logic          filt_init;
      logic          latch_pair;
      logic          latch_m1;
      logic          filt_eval;
      logic          app_init;
      logic          app_eval;
      logic          add_done;
      logic          pop_init;
      logic          pop_lc;
      logic          pop_eval;
      logic          pop_swap;
      logic          rd_last;
      store_sel_type store_sel;
      logic          finish_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       basis_full;
      logic       pairs_empty;
      logic       i_end;
      logic       k_end;
      logic       active_i;
      logic       acc_i;
      logic       k_cand;
      logic       disjoint;
      logic       dominated;
      logic       pk_end;
      logic       out_busy;
   } stat_type;

endpackage

/* rtl/core/gpsm_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gpsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/gpsm_ctrl.sv */
// Sequencer for the pair-set manager: walks the add and pop passes.
// Depends on gpsm_pkg.
module gpsm_ctrl
   import gpsm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.store_sel = SEL_I;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.op)
               OP_ADD: begin
                  if (stat.basis_full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STAT_FULL;
                     state_in = ST_FINISH;
                  end else begin
                     cmd.add_init = 1'b1;
                     state_in = ST_CHK_I;
                  end
               end
               OP_POP: begin
                  if (stat.pairs_empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STAT_EMPTY;
                     state_in = ST_FINISH;
                  end else begin
                     cmd.pop_init = 1'b1;
                     state_in = ST_POP_CHK;
                  end
               end
               OP_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  state_in = ST_FINISH;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         // candidate pairs, chain and product criteria
         ST_CHK_I: begin
            cmd.store_sel = SEL_I;
            if (stat.i_end) begin
               cmd.filt_init = 1'b1;
               state_in = ST_FLT_CHK;
            end else if (!stat.active_i) begin
               cmd.i_inc = 1'b1;
            end else begin
               state_in = ST_EV_I;
            end
         end
         ST_EV_I: begin
            if (stat.disjoint) begin
               cmd.acc_set = 1'b1;
               state_in = ST_CHK_I;
            end else begin
               cmd.chain_start = 1'b1;
               state_in = ST_CHK_K;
            end
         end
         ST_CHK_K: begin
            cmd.store_sel = SEL_K;
            if (stat.k_end) begin
               cmd.acc_set = 1'b1;
               state_in = ST_CHK_I;
            end else if (!stat.k_cand) begin
               cmd.k_inc = 1'b1;
            end else begin
               state_in = ST_EV_K;
            end
         end
         ST_EV_K: begin
            if (stat.dominated) begin
               cmd.i_inc = 1'b1;
               state_in = ST_CHK_I;
            end else begin
               cmd.k_inc = 1'b1;
               state_in = ST_CHK_K;
            end
         end
         // drop old pairs made redundant
         ST_FLT_CHK: begin
            if (stat.pk_end) begin
               cmd.app_init = 1'b1;
               state_in = ST_APP_CHK;
            end else begin
               state_in = ST_FLT_P;
            end
         end
         ST_FLT_P: begin
            cmd.latch_pair = 1'b1;
            cmd.store_sel  = SEL_FIRST;
            state_in = ST_FLT_1;
         end
         ST_FLT_1: begin
            cmd.latch_m1  = 1'b1;
            cmd.store_sel = SEL_SECOND;
            state_in = ST_FLT_2;
         end
         ST_FLT_2: begin
            cmd.filt_eval = 1'b1;
            state_in = ST_FLT_CHK;
         end
         // append survivors, deactivate divided entries
         ST_APP_CHK: begin
            cmd.store_sel = SEL_I;
            if (stat.i_end) begin
               state_in = ST_ADD_END;
            end else if (!(stat.acc_i || stat.active_i)) begin
               cmd.i_inc = 1'b1;
            end else begin
               state_in = ST_APP_EV;
            end
         end
         ST_APP_EV: begin
            cmd.app_eval = 1'b1;
            state_in = ST_APP_CHK;
         end
         ST_ADD_END: begin
            cmd.add_done = 1'b1;
            state_in = ST_FINISH;
         end
         // minimum search over the pair table
         ST_POP_CHK: begin
            if (stat.pk_end) begin
               cmd.rd_last = 1'b1;
               state_in = ST_POP_SWAP;
            end else begin
               state_in = ST_POP_P;
            end
         end
         ST_POP_P: begin
            cmd.latch_pair = 1'b1;
            cmd.store_sel  = SEL_FIRST;
            state_in = ST_POP_1;
         end
         ST_POP_1: begin
            cmd.latch_m1  = 1'b1;
            cmd.store_sel = SEL_SECOND;
            state_in = ST_POP_2;
         end
         ST_POP_2: begin
            cmd.pop_lc = 1'b1;
            state_in = ST_POP_EV;
         end
         ST_POP_EV: begin
            cmd.pop_eval = 1'b1;
            state_in = ST_POP_CHK;
         end
         ST_POP_SWAP: begin
            cmd.pop_swap = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!stat.out_busy) begin
               cmd.finish_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* rtl/core/gpsm_dpath.sv */
// Datapath of the pair-set manager: monomial store, pair table, masks,
// counters and the result register. Depends on gpsm_pkg, gpsm_ram and the
// assertion macro header.
`include "groebner_pair_set_manager_assert.svh"
module gpsm_dpath
   import gpsm_pkg::*;
#(
   parameter int NVARS     = 4,
   parameter int EXP_BITS  = 16,
   parameter int MAX_BASIS = 32,
   parameter int MAX_PAIRS = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_data,
   input  logic         order_is_lex,
   input  cmd_type      cmd,
   output stat_type     stat,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   localparam int WORD_W = NVARS * EXP_BITS;
   localparam int IDX_W  = $clog2(MAX_BASIS);
   localparam int BC_W   = $clog2(MAX_BASIS + 1);
   localparam int PI_W   = $clog2(MAX_PAIRS);
   localparam int PC_W   = $clog2(MAX_PAIRS + 1);
   localparam int PAIR_W = 2 * IDX_W;
   localparam int TOT_W  = EXP_BITS + $clog2(NVARS) + 1;

   // lane helpers, variable 0 in the top lane
   function automatic logic [WORD_W-1:0] unpack_word(logic [63:0] w);
      logic [WORD_W-1:0] r;
      logic [63:0]       s;
      r = '0;
      for (int j = 0; j < NVARS; j++) begin
         s = w >> ((NVARS - 1 - j) * EXP_BITS);
         r[(NVARS-1-j)*EXP_BITS +: EXP_BITS] = s[EXP_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] lcm_word(logic [WORD_W-1:0] a,
                                                  logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int j = 0; j < NVARS; j++) begin
         r[j*EXP_BITS +: EXP_BITS] = (a[j*EXP_BITS +: EXP_BITS] > b[j*EXP_BITS +: EXP_BITS])
                                   ? a[j*EXP_BITS +: EXP_BITS] : b[j*EXP_BITS +: EXP_BITS];
      end
      return r;
   endfunction

   function automatic logic divides_word(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      logic r;
      r = 1'b1;
      for (int j = 0; j < NVARS; j++) begin
         if (a[j*EXP_BITS +: EXP_BITS] > b[j*EXP_BITS +: EXP_BITS]) r = 1'b0;
      end
      return r;
   endfunction

   function automatic logic disjoint_word(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      logic r;
      r = 1'b1;
      for (int j = 0; j < NVARS; j++) begin
         if ((a[j*EXP_BITS +: EXP_BITS] != '0) && (b[j*EXP_BITS +: EXP_BITS] != '0)) begin
            r = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic [TOT_W-1:0] total_word(logic [WORD_W-1:0] a);
      logic [TOT_W-1:0] r;
      r = '0;
      for (int j = 0; j < NVARS; j++) begin
         r = r + TOT_W'(a[j*EXP_BITS +: EXP_BITS]);
      end
      return r;
   endfunction

   // control state
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [BC_W-1:0]      bc_ff, bc_in;
   logic [MAX_BASIS-1:0] active_ff, active_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // working registers
   logic [1:0]           op_ff;
   logic [63:0]          word_ff;
   logic [1:0]           status_ff;
   logic [PAIR_W-1:0]    out_pair_ff;
   logic [WORD_W-1:0]    mh_ff, lhg_ff, m1_ff, lc_ff, best_lc_ff;
   logic [TOT_W-1:0]     best_tot_ff;
   logic                 best_valid_ff, dropped_ff;
   logic [IDX_W-1:0]     i_ff, k_ff;
   logic [PC_W-1:0]      pk_ff, w_ff;
   logic [PI_W-1:0]      choice_ff;
   logic [PAIR_W-1:0]    p_ff, best_pair_ff;
   logic [MAX_BASIS-1:0] acc_ff;
   rsp_word_type         rsp_ff;

   // memories
   logic                 st_wr_en;
   logic [IDX_W-1:0]     st_rd_addr, ih;
   logic [WORD_W-1:0]    st_wr_data, st_rd_data;
   logic                 pt_wr_en;
   logic [PI_W-1:0]      pt_wr_addr, pt_rd_addr;
   logic [PAIR_W-1:0]    pt_wr_data, pt_rd_data;

   // evaluation terms
   logic [WORD_W-1:0]    flt_l;
   logic                 flt_keep, app_pair, app_room, take;
   logic [TOT_W-1:0]     lc_tot;

   assign ih = bc_ff[IDX_W-1:0];

   gpsm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BASIS)) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (ih),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   gpsm_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_PAIRS)) u_pairs (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   // store access
   assign st_wr_en   = cmd.add_init;
   assign st_wr_data = unpack_word(word_ff);
   always_comb begin
      case (cmd.store_sel)
         SEL_I:      st_rd_addr = i_ff;
         SEL_K:      st_rd_addr = k_ff;
         SEL_FIRST:  st_rd_addr = pt_rd_data[PAIR_W-1:IDX_W];
         SEL_SECOND: st_rd_addr = p_ff[IDX_W-1:0];
         default:    st_rd_addr = i_ff;
      endcase
   end

   // criteria on the word just read
   assign flt_l    = lcm_word(m1_ff, st_rd_data);
   assign flt_keep = !(divides_word(mh_ff, flt_l)
                       && (lcm_word(m1_ff, mh_ff) != flt_l)
                       && (lcm_word(st_rd_data, mh_ff) != flt_l));
   assign app_pair = acc_ff[i_ff] && !disjoint_word(mh_ff, st_rd_data);
   assign app_room = pc_ff < PC_W'(MAX_PAIRS);
   assign lc_tot   = total_word(lc_ff);
   assign take     = !best_valid_ff || (lc_tot < best_tot_ff)
                     || ((lc_tot == best_tot_ff) && order_is_lex && (lc_ff <= best_lc_ff));

   // pair table access
   assign pt_rd_addr = cmd.rd_last ? PI_W'(pc_ff - 1'b1) : pk_ff[PI_W-1:0];
   always_comb begin
      pt_wr_en   = 1'b0;
      pt_wr_addr = w_ff[PI_W-1:0];
      pt_wr_data = p_ff;
      if (cmd.filt_eval && flt_keep) begin
         pt_wr_en = 1'b1;
      end else if (cmd.app_eval && app_pair && app_room) begin
         pt_wr_en   = 1'b1;
         pt_wr_addr = pc_ff[PI_W-1:0];
         pt_wr_data = {ih, i_ff};
      end else if (cmd.pop_swap) begin
         pt_wr_en   = 1'b1;
         pt_wr_addr = choice_ff;
         pt_wr_data = pt_rd_data;
      end
   end

   // next values of control state
   always_comb begin
      pc_in        = pc_ff;
      bc_in        = bc_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.clear_all) begin
         pc_in     = '0;
         bc_in     = '0;
         active_in = '0;
      end
      if (cmd.app_init) pc_in = w_ff;
      if (cmd.app_eval) begin
         if (app_pair && app_room) pc_in = pc_ff + 1'b1;
         if (active_ff[i_ff] && divides_word(mh_ff, st_rd_data)) active_in[i_ff] = 1'b0;
      end
      if (cmd.add_done) begin
         active_in[ih] = 1'b1;
         bc_in = bc_ff + 1'b1;
      end
      if (cmd.pop_swap) pc_in = pc_ff - 1'b1;
      if (cmd.finish_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         bc_ff        <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         bc_ff        <= bc_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff       <= req_data.operation;
         word_ff     <= req_data.lead_exponents;
         status_ff   <= STAT_OK;
         out_pair_ff <= '0;
      end
      if (cmd.set_status) status_ff <= cmd.status_code;
      if (cmd.add_init) begin
         mh_ff      <= unpack_word(word_ff);
         i_ff       <= '0;
         acc_ff     <= '0;
         dropped_ff <= 1'b0;
      end
      if (cmd.i_inc) i_ff <= i_ff + 1'b1;
      if (cmd.acc_set) begin
         acc_ff[i_ff] <= 1'b1;
         i_ff         <= i_ff + 1'b1;
      end
      if (cmd.chain_start) begin
         lhg_ff <= lcm_word(mh_ff, st_rd_data);
         k_ff   <= '0;
      end
      if (cmd.k_inc) k_ff <= k_ff + 1'b1;
      if (cmd.filt_init) begin
         pk_ff <= '0;
         w_ff  <= '0;
      end
      if (cmd.latch_pair) p_ff <= pt_rd_data;
      if (cmd.latch_m1) m1_ff <= st_rd_data;
      if (cmd.filt_eval) begin
         pk_ff <= pk_ff + 1'b1;
         if (flt_keep) w_ff <= w_ff + 1'b1;
      end
      if (cmd.app_init) i_ff <= '0;
      if (cmd.app_eval) begin
         i_ff <= i_ff + 1'b1;
         if (app_pair && !app_room) dropped_ff <= 1'b1;
      end
      if (cmd.add_done) status_ff <= dropped_ff ? STAT_DROP : STAT_OK;
      if (cmd.pop_init) begin
         pk_ff         <= '0;
         best_valid_ff <= 1'b0;
      end
      if (cmd.pop_lc) lc_ff <= lcm_word(m1_ff, st_rd_data);
      if (cmd.pop_eval) begin
         pk_ff <= pk_ff + 1'b1;
         if (take) begin
            best_valid_ff <= 1'b1;
            best_tot_ff   <= lc_tot;
            best_lc_ff    <= lc_ff;
            best_pair_ff  <= p_ff;
            choice_ff     <= pk_ff[PI_W-1:0];
         end
      end
      if (cmd.pop_swap) out_pair_ff <= best_pair_ff;
      if (cmd.finish_load) begin
         rsp_ff.pair_first  <= 5'(out_pair_ff[PAIR_W-1:IDX_W]);
         rsp_ff.pair_second <= 5'(out_pair_ff[IDX_W-1:0]);
         rsp_ff.status      <= status_ff;
         rsp_ff.pairs_left  <= 8'(pc_ff);
         rsp_ff.basis_size  <= 6'(bc_ff);
      end
   end

   // status to the sequencer
   always_comb begin
      stat.op          = op_ff;
      stat.basis_full  = bc_ff == BC_W'(MAX_BASIS);
      stat.pairs_empty = pc_ff == '0;
      stat.i_end       = i_ff == ih;
      stat.k_end       = k_ff == ih;
      stat.active_i    = active_ff[i_ff];
      stat.acc_i       = acc_ff[i_ff];
      stat.k_cand      = ((k_ff < i_ff) && acc_ff[k_ff]) || ((k_ff > i_ff) && active_ff[k_ff]);
      stat.disjoint    = disjoint_word(mh_ff, st_rd_data);
      stat.dominated   = divides_word(lcm_word(mh_ff, st_rd_data), lhg_ff);
      stat.pk_end      = pk_ff == pc_ff;
      stat.out_busy    = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `GPSM_ASSERT_IMPLIES(a_pc_bound, clock, reset, 1'b1, pc_ff <= PC_W'(MAX_PAIRS))
   `GPSM_ASSERT_IMPLIES(a_bc_bound, clock, reset, 1'b1, bc_ff <= BC_W'(MAX_BASIS))
   `GPSM_ASSERT_NEXT(a_add_grows, clock, reset, cmd.add_done, bc_ff == $past(bc_ff) + 1'b1)
   `GPSM_ASSERT_IMPLIES(a_empty_no_pair, clock, reset, rsp_valid_ff && (rsp_ff.status == STAT_EMPTY), (rsp_ff.pair_first == '0) && (rsp_ff.pair_second == '0))

endmodule

/* rtl/core/groebner_pair_set_manager.sv */
// Top level of the pair-set manager: sequencer, datapath, config register.
// Depends on gpsm_pkg, gpsm_ctrl and gpsm_dpath.
//
// One word in gives one word out. The monomial store has a single read port
// and every step that needs a stored monomial waits for its registered read,
// which sets the latency. The next word is taken once the result is loaded
// into the output register.
module groebner_pair_set_manager
   import gpsm_pkg::*;
#(
   parameter int NVARS     = 4,
   parameter int EXP_BITS  = 16,
   parameter int MAX_BASIS = 32,
   parameter int MAX_PAIRS = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;
   logic     order_is_lex_ff;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         order_is_lex_ff <= 1'b0;
      end else if (csr_wr_en) begin
         order_is_lex_ff <= csr_wr_data;
      end
   end

   gpsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gpsm_dpath #(
      .NVARS     (NVARS),
      .EXP_BITS  (EXP_BITS),
      .MAX_BASIS (MAX_BASIS),
      .MAX_PAIRS (MAX_PAIRS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .order_is_lex (order_is_lex_ff),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

/* verif/groebner_pair_set_manager_test.sv */
// Self-checking testbench for the pair-set manager: directed and random words,
// predicted by a scoreboard class. Depends on gpsm_pkg and groebner_pair_set_manager.
`timescale 1ns / 1ps

module groebner_pair_set_manager_test
   import gpsm_pkg::*;
();

   localparam int CYCLE_LIMIT = 10000000;
   localparam int PHASE_WORDS = 108;

   // four 16-bit exponents, index 3 holds variable 0
   typedef logic [3:0][15:0] mono_type;

   class pair_set_scoreboard;
      mono_type     store [32];
      bit           active [32];
      logic [4:0]   pfirst [128];
      logic [4:0]   psecond [128];
      int           pcount, bcount;
      bit           lex;
      rsp_word_type pending_rsp [$];
      int           errors, results, n_pop, n_empty, n_full, n_drop;

      function new();
         lex = 0;
         errors = 0; results = 0; n_pop = 0; n_empty = 0; n_full = 0; n_drop = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (active[i]) active[i] = 0;
         pcount = 0;
         bcount = 0;
      endfunction

      function bit divides(mono_type a, mono_type b);
         for (int v = 0; v < 4; v++) if (a[v] > b[v]) return 0;
         return 1;
      endfunction

      function bit disjoint(mono_type a, mono_type b);
         for (int v = 0; v < 4; v++) if (a[v] != 0 && b[v] != 0) return 0;
         return 1;
      endfunction

      function mono_type lcm(mono_type a, mono_type b);
         mono_type o;
         for (int v = 0; v < 4; v++) o[v] = (a[v] > b[v]) ? a[v] : b[v];
         return o;
      endfunction

      // add a leading monomial under the chain, product and removal criteria
      function bit add_mono(mono_type h);
         int       acc [$];
         int       ih, kept;
         bit       dom, keep, dropped;
         mono_type l, m1, m2;
         ih = bcount;
         dropped = 0;
         store[ih] = h;
         for (int i = 0; i < ih; i++) begin
            if (!active[i]) continue;
            if (!disjoint(h, store[i])) begin
               l = lcm(h, store[i]);
               dom = 0;
               foreach (acc[k]) if (divides(lcm(h, store[acc[k]]), l)) dom = 1;
               for (int k = i + 1; k < ih; k++)
                  if (active[k] && divides(lcm(h, store[k]), l)) dom = 1;
               if (dom) continue;
            end
            acc.push_back(i);
         end
         // drop old pairs made redundant by h
         kept = 0;
         for (int k = 0; k < pcount; k++) begin
            m1 = store[pfirst[k]];
            m2 = store[psecond[k]];
            l = lcm(m1, m2);
            keep = 1;
            if (divides(h, l) && lcm(m1, h) != l && lcm(m2, h) != l) keep = 0;
            if (keep) begin
               pfirst[kept] = pfirst[k];
               psecond[kept] = psecond[k];
               kept++;
            end
         end
         pcount = kept;
         foreach (acc[k]) begin
            if (disjoint(h, store[acc[k]])) continue;
            if (pcount < 128) begin
               pfirst[pcount] = ih[4:0];
               psecond[pcount] = acc[k][4:0];
               pcount++;
            end else dropped = 1;
         end
         for (int i = 0; i < ih; i++)
            if (active[i] && divides(h, store[i])) active[i] = 0;
         active[ih] = 1;
         bcount = ih + 1;
         return dropped;
      endfunction

      // pick the pair with the smallest lcm degree, swap last into its slot
      function void pop_pair(output logic [4:0] f, output logic [4:0] s);
         mono_type    best, lc;
         int unsigned best_total, total;
         int          choice;
         bit          take;
         best = '1;
         best_total = '1;
         choice = 0;
         for (int i = 0; i < pcount; i++) begin
            lc = lcm(store[pfirst[i]], store[psecond[i]]);
            total = lc[0] + lc[1] + lc[2] + lc[3];
            take = 1;
            if (total > best_total) take = 0;
            else if (total == best_total) begin
               if (lex) begin
                  for (int v = 3; v >= 0; v--) begin
                     if (lc[v] > best[v]) begin take = 0; break; end
                     if (lc[v] < best[v]) break;
                  end
               end else take = 0;
            end
            if (take) begin
               best = lc;
               best_total = total;
               choice = i;
            end
         end
         f = pfirst[choice];
         s = psecond[choice];
         pfirst[choice] = pfirst[pcount - 1];
         psecond[choice] = psecond[pcount - 1];
         pcount--;
      endfunction

      function void note(req_word_type w);
         rsp_word_type e;
         e = '0;
         e.status = STAT_OK;
         case (w.operation)
            OP_ADD: begin
               if (bcount >= 32) e.status = STAT_FULL;
               else if (add_mono(w.lead_exponents)) e.status = STAT_DROP;
            end
            OP_POP: begin
               if (pcount == 0) e.status = STAT_EMPTY;
               else pop_pair(e.pair_first, e.pair_second);
            end
            OP_CLEAR: wipe();
            default: ;
         endcase
         e.pairs_left = pcount[7:0];
         e.basis_size = bcount[5:0];
         pending_rsp.push_back(e);
      endfunction

      function void check(rsp_word_type r);
         rsp_word_type e;
         results++;
         if (pending_rsp.size() == 0) begin
            $error("result word with nothing expected: %h", r);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (r.pair_first !== e.pair_first) begin
            $error("pair_first expected %0d got %0d", e.pair_first, r.pair_first);
            errors++;
         end
         if (r.pair_second !== e.pair_second) begin
            $error("pair_second expected %0d got %0d", e.pair_second, r.pair_second);
            errors++;
         end
         if (r.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, r.status);
            errors++;
         end
         if (r.pairs_left !== e.pairs_left) begin
            $error("pairs_left expected %0d got %0d", e.pairs_left, r.pairs_left);
            errors++;
         end
         if (r.basis_size !== e.basis_size) begin
            $error("basis_size expected %0d got %0d", e.basis_size, r.basis_size);
            errors++;
         end
         if (e.status == STAT_OK && e.pair_first != e.pair_second) n_pop++;
         if (e.status == STAT_EMPTY) n_empty++;
         if (e.status == STAT_FULL) n_full++;
         if (e.status == STAT_DROP) n_drop++;
      endfunction
   endclass

   logic         clock = 0;
   logic         reset;
   logic         req_valid, req_ready, rsp_valid, rsp_ready;
   req_word_type req_data;
   rsp_word_type rsp_data;
   logic         csr_wr_en, csr_wr_data;

   pair_set_scoreboard sb;
   bit send_idle, recv_stall;
   int hold_cycles = 0;
   int cycles = 0;

   groebner_pair_set_manager uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: check words, stall at random, long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_data);
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 0;
      end else
         rsp_ready <= recv_stall ? ($urandom_range(99) >= 84) : 1'b1;
   end

   // offer one word, hold it until taken, then maybe idle
   task automatic send_word(logic [1:0] op, logic [63:0] expo);
      req_word_type w;
      w.operation = op;
      w.lead_exponents = expo;
      req_valid <= 1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      sb.note(w);
      if (send_idle && $urandom_range(99) < 84) begin
         req_valid <= 0;
         while ($urandom_range(99) < 84) @(posedge clock);
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_order(bit v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.lex = v;
      @(posedge clock);
   endtask

   // small exponents mostly, so pairs interact; some full-range words
   function automatic logic [63:0] rand_mono();
      mono_type m;
      int r;
      r = $urandom_range(15);
      if (r == 0) return {$urandom, $urandom};
      m = '0;
      if (r == 1) m[$urandom_range(3)] = 16'($urandom_range(1, 4));
      else for (int v = 0; v < 4; v++) m[v] = 16'($urandom_range(3));
      return m;
   endfunction

   // edge cases: empty pop, unused code, chain triple, unit, max, full reset
   task automatic directed_words();
      send_word(OP_POP, '0);
      send_word(OP_NONE, '1);
      send_word(OP_ADD, 64'h0001_0001_0000_0000);
      send_word(OP_ADD, 64'h0000_0001_0001_0000);
      send_word(OP_ADD, 64'h0001_0000_0001_0000);
      send_word(OP_ADD, 64'h0000_0000_0000_0002);
      send_word(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_ADD, 64'h0001_0000_0000_0001);
      send_word(OP_POP, '0);
      send_word(OP_POP, '0);
      send_word(OP_ADD, 64'h0000_0001_0000_0001);
      send_word(OP_ADD, 64'h0000_0000_0000_0000);
      repeat (4) send_word(OP_POP, '0);
      send_word(OP_CLEAR, 64'h5555_AAAA_5555_AAAA);
      send_word(OP_ADD, 64'h0002_0000_0000_0000);
      send_word(OP_ADD, 64'h0000_0002_0000_0000);
      send_word(OP_ADD, 64'h0001_0001_0000_0000);
      send_word(OP_ADD, 64'h0001_0000_0001_0000);
      send_word(OP_POP, '0);
      send_word(OP_POP, '0);
      send_word(OP_CLEAR, '0);
   endtask

   task automatic random_words(int n);
      int r;
      repeat (n) begin
         r = $urandom_range(999);
         if (r < 15) send_word(OP_CLEAR, {$urandom, $urandom});
         else if (r < 25) send_word(OP_NONE, {$urandom, $urandom});
         else if (r < 625) send_word(OP_ADD, rand_mono());
         else send_word(OP_POP, {$urandom, $urandom});
      end
   endtask

   initial begin
      sb = new();
      reset <= 1;
      req_valid <= 0;
      req_data <= '0;
      rsp_ready <= 0;
      csr_wr_en <= 0;
      csr_wr_data <= 0;
      send_idle = 0;
      recv_stall = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_order(0);
      directed_words();
      for (int ph = 0; ph < 4; ph++) begin
         wait_drained();
         write_order(ph % 2 == 0);
         send_idle = (ph == 1 || ph == 3);
         recv_stall = (ph == 2 || ph == 3);
         if (ph == 0) hold_cycles = 400;
         if (ph == 1) directed_words();
         random_words(PHASE_WORDS);
      end
      wait_drained();
      repeat (50) @(posedge clock);
      $display("Ran %0d result words over both tie-break orders and four idling mixes;",
               sb.results);
      $display("%0d pops, %0d empty pops, %0d basis-full adds, %0d adds with dropped pairs.",
               sb.n_pop, sb.n_empty, sb.n_full, sb.n_drop);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
